// ----- rtl/mfmt_pkg.sv -----
// -----------------------------------------------------------------------------
// Motor feedback multi-turn tracker package
// Shared widths, slot codes, register indexes and the per-slot state record.
// -----------------------------------------------------------------------------
package mfmt_pkg;

   localparam int NUM_SLOTS  = 9;
   localparam int SLOT_W     = 4;
   localparam int ID_W       = 11;
   localparam int ENC_W      = 16;
   localparam int RAW_W      = 16;
   localparam int RATE_W     = 17;
   localparam int TURNS_W    = 32;
   localparam int FRAMES_W   = 32;
   localparam int CSR_IDX_W  = 3;

   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 136;
   localparam int RSP_USER_W = 2;

   // Encoder scale and calibration length
   localparam int COUNTS_PER_TURN   = 8192;
   localparam int CALIBRATION_LIMIT = 50;

   // Slot codes
   localparam logic [SLOT_W-1:0] SLOT_CHASSIS0 = 4'd0;
   localparam logic [SLOT_W-1:0] SLOT_YAW      = 4'd4;
   localparam logic [SLOT_W-1:0] SLOT_FRICTION = 4'd5;
   localparam logic [SLOT_W-1:0] SLOT_TRIGGER  = 4'd7;
   localparam logic [SLOT_W-1:0] SLOT_PITCH    = 4'd8;
   localparam logic [SLOT_W-1:0] SLOT_LAST     = 4'd8;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CHASSIS_BASE_ID  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_YAW_ID           = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRICTION_BASE_ID = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIGGER_ID       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PITCH_ID         = 3'd4;

   // Register reset values
   localparam logic [ID_W-1:0] RST_CHASSIS_BASE_ID  = 11'd513;
   localparam logic [ID_W-1:0] RST_YAW_ID           = 11'd517;
   localparam logic [ID_W-1:0] RST_FRICTION_BASE_ID = 11'd513;
   localparam logic [ID_W-1:0] RST_TRIGGER_ID       = 11'd515;
   localparam logic [ID_W-1:0] RST_PITCH_ID         = 11'd518;

   typedef struct packed {
      logic        [ENC_W-1:0]    position;
      logic        [ENC_W-1:0]    offset;
      logic        [TURNS_W-1:0]  turns;
      logic        [FRAMES_W-1:0] frames;
      logic signed [RATE_W-1:0]   rate;
      logic signed [RAW_W-1:0]    speed;
      logic signed [RAW_W-1:0]    current;
   } slot_state_type;

endpackage

// ----- rtl/motor_feedback_multiturn_tracker_top.sv -----
// -----------------------------------------------------------------------------
// Motor feedback multi-turn tracker
// Routes feedback frames to nine motor slots, calibrates the zero offset and
// unwraps the encoder into turns, rate and a total count.
// -----------------------------------------------------------------------------
// Each accepted frame is matched to a slot from its bus and identifier, then
// the slot record is read from a nine-entry state memory, updated and written
// back. A frame passes the memory read register, then the update and result
// register, and a new frame may be accepted every cycle unless the result stalls;
// back-to-back frames to the same slot are served by forwarding the write-back
// data into the read register. Slots start at zero after reset through one
// valid bit per entry, so no clearing pass is needed. Frames that match no slot
// return a result with matched low and all other fields zero. The user writes
// registers through the csr port only while no frame is in flight; the block does not enforce it.
module motor_feedback_multiturn_tracker_top (
   input  logic                                 clock,
   input  logic                                 reset,
   // request: tuser = bus
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic                                 req_tuser,
   // tdata: frame_id[10:0], encoder_raw[26:11], speed_raw[42:27],
   //        current_raw[58:43], zero pad
   input  logic [mfmt_pkg::REQ_DATA_W-1:0]      req_tdata,
   // response: tuser = matched[0], calibrating[1]
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [mfmt_pkg::RSP_USER_W-1:0]      rsp_tuser,
   // tdata: motor_index[3:0], position[19:4], rate[36:20], turns[68:37],
   //        total_count[100:69], speed[116:101], current[132:117], zero pad
   output logic [mfmt_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // configuration write
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mfmt_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mfmt_pkg::ID_W-1:0]            csr_data
);

   localparam logic [31:0] CPT_WORD = 32'(mfmt_pkg::COUNTS_PER_TURN);
   localparam logic signed [17:0] HALF_TURN = 18'(mfmt_pkg::COUNTS_PER_TURN / 2);
   localparam logic signed [17:0] FULL_TURN = 18'(mfmt_pkg::COUNTS_PER_TURN);
   localparam logic [mfmt_pkg::FRAMES_W-1:0] CAL_LIMIT =
      32'(mfmt_pkg::CALIBRATION_LIMIT);

   // ---------------------------------------------------------------- config
   logic [mfmt_pkg::ID_W-1:0] chassis_base_ff, yaw_id_ff, friction_base_ff;
   logic [mfmt_pkg::ID_W-1:0] trigger_id_ff, pitch_id_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         chassis_base_ff  <= mfmt_pkg::RST_CHASSIS_BASE_ID;
         yaw_id_ff        <= mfmt_pkg::RST_YAW_ID;
         friction_base_ff <= mfmt_pkg::RST_FRICTION_BASE_ID;
         trigger_id_ff    <= mfmt_pkg::RST_TRIGGER_ID;
         pitch_id_ff      <= mfmt_pkg::RST_PITCH_ID;
      end else if (csr_valid) begin
         case (csr_index)
            mfmt_pkg::CSR_CHASSIS_BASE_ID:  chassis_base_ff  <= csr_data;
            mfmt_pkg::CSR_YAW_ID:           yaw_id_ff        <= csr_data;
            mfmt_pkg::CSR_FRICTION_BASE_ID: friction_base_ff <= csr_data;
            mfmt_pkg::CSR_TRIGGER_ID:       trigger_id_ff    <= csr_data;
            mfmt_pkg::CSR_PITCH_ID:         pitch_id_ff      <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------- slot match
   logic [mfmt_pkg::ID_W-1:0]   req_id;
   logic [mfmt_pkg::ENC_W-1:0]  req_enc;
   logic [mfmt_pkg::RAW_W-1:0]  req_spd, req_cur;
   logic [mfmt_pkg::ID_W-1:0]   chassis_ofs, friction_ofs;
   logic                        chassis_hit, friction_hit;
   logic                        match;
   logic [mfmt_pkg::SLOT_W-1:0] slot;

   assign req_id  = req_tdata[10:0];
   assign req_enc = req_tdata[26:11];
   assign req_spd = req_tdata[42:27];
   assign req_cur = req_tdata[58:43];

   assign chassis_ofs  = req_id - chassis_base_ff;
   assign friction_ofs = req_id - friction_base_ff;
   // ranges do not wrap past the top identifier
   assign chassis_hit  = (req_id >= chassis_base_ff) &&
                         ({1'b0, req_id} <= {1'b0, chassis_base_ff} + 12'd3);
   assign friction_hit = (req_id >= friction_base_ff) &&
                         ({1'b0, req_id} <= {1'b0, friction_base_ff} + 12'd1);

   always_comb begin
      match = 1'b1;
      slot  = mfmt_pkg::SLOT_CHASSIS0;
      if (!req_tuser) begin
         if (chassis_hit) begin
            slot = mfmt_pkg::SLOT_CHASSIS0 + {2'b00, chassis_ofs[1:0]};
         end else if (req_id == yaw_id_ff) begin
            slot = mfmt_pkg::SLOT_YAW;
         end else begin
            match = 1'b0;
         end
      end else begin
         if (friction_hit) begin
            slot = mfmt_pkg::SLOT_FRICTION + {3'b000, friction_ofs[0]};
         end else if (req_id == trigger_id_ff) begin
            slot = mfmt_pkg::SLOT_TRIGGER;
         end else if (req_id == pitch_id_ff) begin
            slot = mfmt_pkg::SLOT_PITCH;
         end else begin
            match = 1'b0;
         end
      end
   end

   // -------------------------------------------------------- handshake
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic s1_adv, req_fire;

   assign s1_adv     = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_fire   = req_tvalid && req_tready;

   assign s1_valid_in  = req_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_adv ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ------------------------------------------------------ state memory
   mfmt_pkg::slot_state_type slot_mem [mfmt_pkg::NUM_SLOTS];
   logic [mfmt_pkg::NUM_SLOTS-1:0] slot_valid_ff;

   logic                        s1_match_ff;
   logic [mfmt_pkg::SLOT_W-1:0] s1_slot_ff;
   logic [mfmt_pkg::ENC_W-1:0]  s1_enc_ff;
   logic [mfmt_pkg::RAW_W-1:0]  s1_spd_ff, s1_cur_ff;
   mfmt_pkg::slot_state_type    rd_data_ff;
   logic                        rd_hit_ff;

   logic                        wr_en;
   mfmt_pkg::slot_state_type    wr_data;

   assign wr_en = s1_valid_ff && s1_adv && s1_match_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[s1_slot_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
      end else if (wr_en) begin
         slot_valid_ff[s1_slot_ff] <= 1'b1;
      end
   end

   // read port; forward a write-back to the same slot on this edge
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_match_ff <= match;
         s1_slot_ff  <= slot;
         s1_enc_ff   <= req_enc;
         s1_spd_ff   <= req_spd;
         s1_cur_ff   <= req_cur;
         if (wr_en && (s1_slot_ff == slot)) begin
            rd_data_ff <= wr_data;
            rd_hit_ff  <= 1'b1;
         end else begin
            rd_data_ff <= slot_mem[slot];
            rd_hit_ff  <= slot_valid_ff[slot];
         end
      end
   end

   // ----------------------------------------------------------- update
   mfmt_pkg::slot_state_type cur_st;
   logic                     cal_slot, calib;
   logic signed [17:0]       diff, rate_full;
   logic [31:0]              turn_counts, total;

   assign cur_st   = rd_hit_ff ? rd_data_ff : '0;
   assign cal_slot = (s1_slot_ff != mfmt_pkg::SLOT_YAW) &&
                     (s1_slot_ff != mfmt_pkg::SLOT_PITCH);
   assign calib    = cal_slot && (cur_st.frames <= CAL_LIMIT);
   assign diff     = $signed({2'b00, s1_enc_ff}) - $signed({2'b00, cur_st.position});

   always_comb begin
      wr_data          = cur_st;
      wr_data.position = s1_enc_ff;
      rate_full        = diff;
      if (cal_slot) begin
         wr_data.frames = cur_st.frames + 32'd1;
      end
      if (calib) begin
         wr_data.offset = s1_enc_ff;
      end else begin
         if (diff > HALF_TURN) begin
            wr_data.turns = cur_st.turns - 32'd1;
            rate_full     = diff - FULL_TURN;
         end else if (diff < -HALF_TURN) begin
            wr_data.turns = cur_st.turns + 32'd1;
            rate_full     = diff + FULL_TURN;
         end
         wr_data.rate    = rate_full[16:0];
         wr_data.speed   = s1_spd_ff;
         wr_data.current = s1_cur_ff;
      end
   end

   assign turn_counts = wr_data.turns * CPT_WORD;
   assign total       = turn_counts + {16'h0000, wr_data.position}
                        - {16'h0000, wr_data.offset};

   // --------------------------------------------------- result register
   logic [mfmt_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [mfmt_pkg::RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;

   always_comb begin
      if (s1_match_ff) begin
         rsp_data_in = {3'b000, wr_data.current, wr_data.speed, total,
                        wr_data.turns, wr_data.rate, wr_data.position, s1_slot_ff};
         rsp_user_in = {calib, 1'b1};
      end else begin
         rsp_data_in = '0;
         rsp_user_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef ASSERT_OFF
   a_unmatched_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> (rsp_tdata == '0) && !rsp_tuser[1])
      else $error("unmatched beat carries nonzero fields");

   a_index_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[3:0] <= mfmt_pkg::SLOT_LAST)
      else $error("slot index out of range");

   a_no_cal_yaw_pitch : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |->
         (rsp_tdata[3:0] != mfmt_pkg::SLOT_YAW) &&
         (rsp_tdata[3:0] != mfmt_pkg::SLOT_PITCH))
      else $error("yaw or pitch beat marked calibrating");

   a_fire_fills_stage : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> s1_valid_ff)
      else $error("accepted beat lost before update stage");

   a_write_marks_valid : assert property (@(posedge clock) disable iff (reset)
      wr_en |=> slot_valid_ff[$past(s1_slot_ff)])
      else $error("written slot not marked valid");
`endif

endmodule

// ----- verif/motor_feedback_checker.sv -----
// -----------------------------------------------------------------------------
// Motor feedback tracker checker
// Watches the frame, result and csr channels, tracks the nine motor slots
// frame by frame and compares every result beat with the oldest prediction.
// -----------------------------------------------------------------------------
module motor_feedback_checker
   import mfmt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic                  req_tuser,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_USER_W-1:0] rsp_tuser,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [ID_W-1:0]       csr_data,
   output int                    mismatch_count,
   output int                    outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic                matched;
      logic                calibrating;
      logic [SLOT_W-1:0]   slot;
      logic [ENC_W-1:0]    position;
      logic [RATE_W-1:0]   rate;
      logic [TURNS_W-1:0]  turns;
      logic [TURNS_W-1:0]  total;
      logic [RAW_W-1:0]    speed;
      logic [RAW_W-1:0]    current;
   } feedback_type;

   feedback_type expected_feedback[$];

   logic [ID_W-1:0] chassis_base, yaw_match, friction_base, trigger_match, pitch_match;

   logic [ENC_W-1:0]    position_mem [NUM_SLOTS];
   logic [ENC_W-1:0]    offset_mem   [NUM_SLOTS];
   logic [TURNS_W-1:0]  turns_mem    [NUM_SLOTS];
   logic [FRAMES_W-1:0] frames_mem   [NUM_SLOTS];
   logic [RATE_W-1:0]   rate_mem     [NUM_SLOTS];
   logic [RAW_W-1:0]    speed_mem    [NUM_SLOTS];
   logic [RAW_W-1:0]    current_mem  [NUM_SLOTS];

   // Slot number for a frame, -1 when no motor owns it; ranges never wrap past 2047
   function automatic int route_frame(logic bus, logic [ID_W-1:0] id);
      if (!bus) begin
         if (id >= chassis_base && 12'(id) <= 12'(chassis_base) + 12'd3)
            return int'(id - chassis_base);
         if (id == yaw_match)
            return int'(SLOT_YAW);
      end else begin
         if (id >= friction_base && 12'(id) <= 12'(friction_base) + 12'd1)
            return int'(SLOT_FRICTION) + int'(id - friction_base);
         if (id == trigger_match)
            return int'(SLOT_TRIGGER);
         if (id == pitch_match)
            return int'(SLOT_PITCH);
      end
      return -1;
   endfunction

   function automatic feedback_type track_frame(logic bus, logic [REQ_DATA_W-1:0] data);
      int               s;
      int               diff;
      int               step;
      logic             calib;
      logic [ENC_W-1:0] enc;
      feedback_type     r;
      r = '{default: '0};
      enc = data[26:11];
      s = route_frame(bus, data[10:0]);
      if (s < 0)
         return r;
      calib = 1'b0;
      // yaw and pitch never calibrate and keep no frame count
      if (s != SLOT_YAW && s != SLOT_PITCH) begin
         calib = (frames_mem[s] <= CALIBRATION_LIMIT);
         frames_mem[s] = frames_mem[s] + 1;
      end
      if (calib) begin
         position_mem[s] = enc;
         offset_mem[s] = enc;
      end else begin
         diff = int'(enc) - int'(position_mem[s]);
         position_mem[s] = enc;
         // a jump beyond half a turn is a wrap
         if (diff > COUNTS_PER_TURN / 2) begin
            turns_mem[s] = turns_mem[s] - 1;
            step = diff - COUNTS_PER_TURN;
         end else if (diff < -(COUNTS_PER_TURN / 2)) begin
            turns_mem[s] = turns_mem[s] + 1;
            step = diff + COUNTS_PER_TURN;
         end else begin
            step = diff;
         end
         rate_mem[s] = RATE_W'(step);
         speed_mem[s] = data[42:27];
         current_mem[s] = data[58:43];
      end
      r.matched = 1'b1;
      r.calibrating = calib;
      r.slot = SLOT_W'(s);
      r.position = position_mem[s];
      r.rate = rate_mem[s];
      r.turns = turns_mem[s];
      r.total = turns_mem[s] * COUNTS_PER_TURN + position_mem[s] - offset_mem[s];
      r.speed = speed_mem[s];
      r.current = current_mem[s];
      return r;
   endfunction

   task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
      if (want_v !== got_v) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("checker: %s expected %0h, actual %0h", name, want_v, got_v);
      end
   endtask

   always @(posedge clock) begin
      feedback_type want;
      if (reset) begin
         chassis_base = RST_CHASSIS_BASE_ID;
         yaw_match = RST_YAW_ID;
         friction_base = RST_FRICTION_BASE_ID;
         trigger_match = RST_TRIGGER_ID;
         pitch_match = RST_PITCH_ID;
         for (int k = 0; k < NUM_SLOTS; k++) begin
            position_mem[k] = '0;
            offset_mem[k] = '0;
            turns_mem[k] = '0;
            frames_mem[k] = '0;
            rate_mem[k] = '0;
            speed_mem[k] = '0;
            current_mem[k] = '0;
         end
         expected_feedback.delete();
         mismatch_count = 0;
      end else begin
         // check the result beat before queueing a frame taken on the same edge
         if (rsp_tvalid && rsp_tready) begin
            if (expected_feedback.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("checker: result beat with no frame outstanding");
            end else begin
               want = expected_feedback.pop_front();
               check_field("matched", 32'(want.matched), 32'(rsp_tuser[0]));
               check_field("calibrating", 32'(want.calibrating), 32'(rsp_tuser[1]));
               check_field("motor_index", 32'(want.slot), 32'(rsp_tdata[3:0]));
               check_field("position", 32'(want.position), 32'(rsp_tdata[19:4]));
               check_field("rate", 32'(want.rate), 32'(rsp_tdata[36:20]));
               check_field("turns", want.turns, rsp_tdata[68:37]);
               check_field("total_count", want.total, rsp_tdata[100:69]);
               check_field("speed", 32'(want.speed), 32'(rsp_tdata[116:101]));
               check_field("current", 32'(want.current), 32'(rsp_tdata[132:117]));
            end
         end
         if (req_tvalid && req_tready)
            expected_feedback.push_back(track_frame(req_tuser, req_tdata));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CHASSIS_BASE_ID:  chassis_base = csr_data;
               CSR_YAW_ID:           yaw_match = csr_data;
               CSR_FRICTION_BASE_ID: friction_base = csr_data;
               CSR_TRIGGER_ID:       trigger_match = csr_data;
               CSR_PITCH_ID:         pitch_match = csr_data;
               default: ;
            endcase
         end
      end
      outstanding <= expected_feedback.size();
   end

endmodule

// ----- verif/tb.sv -----
// -----------------------------------------------------------------------------
// Motor feedback tracker testbench
// Drives directed and random feedback frames through several identifier maps
// with random idling on both channels; the checker predicts and compares.
// -----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mfmt_pkg::*;

   localparam int CSR_COUNT      = 5;
   localparam int PHASE_COUNT    = 6;
   localparam int RANDOM_FRAMES  = 280;
   localparam int SETTLE_CYCLES  = 4;
   localparam int WATCHDOG_LIMIT = 4000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic                  req_tuser = 1'b0;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [ID_W-1:0]       csr_data = '0;

   int mismatch_total;
   int pending_results;
   int quiet_cycles = 0;
   int idle_pct = 0;
   int stall_pct = 0;

   logic [ID_W-1:0]  active_ids [CSR_COUNT];
   logic [ID_W-1:0]  id_sets    [PHASE_COUNT][CSR_COUNT];
   logic [ENC_W-1:0] enc_trail  [NUM_SLOTS];

   motor_feedback_multiturn_tracker_top DUT (.*);

   motor_feedback_checker checker_i (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tuser, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tuser, .rsp_tdata,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .mismatch_count (mismatch_total),
      .outstanding    (pending_results)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic send_frame(input logic bus, input logic [ID_W-1:0] id,
                             input logic [ENC_W-1:0] enc,
                             input logic [RAW_W-1:0] spd, input logic [RAW_W-1:0] cur);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= bus;
      req_tdata <= {5'd0, cur, spd, enc, id};
      do @(posedge clock); while (!req_tready);
   endtask

   // Mostly frames for a live slot with a plausible encoder step, some near
   // misses on the identifier and some noise
   task automatic random_frame();
      int               slot;
      int               pick;
      int               delta;
      logic             bus;
      logic [ID_W-1:0]  id;
      logic [ENC_W-1:0] enc;
      slot = $urandom_range(NUM_SLOTS - 1);
      if (slot < SLOT_YAW) begin
         bus = 1'b0;
         id = active_ids[CSR_CHASSIS_BASE_ID] + ID_W'(slot);
      end else if (slot == SLOT_YAW) begin
         bus = 1'b0;
         id = active_ids[CSR_YAW_ID];
      end else if (slot < SLOT_TRIGGER) begin
         bus = 1'b1;
         id = active_ids[CSR_FRICTION_BASE_ID] + ID_W'(slot - SLOT_FRICTION);
      end else if (slot == SLOT_TRIGGER) begin
         bus = 1'b1;
         id = active_ids[CSR_TRIGGER_ID];
      end else begin
         bus = 1'b1;
         id = active_ids[CSR_PITCH_ID];
      end
      pick = $urandom_range(99);
      if (pick >= 90) begin
         bus = 1'($urandom_range(1));
         id = ID_W'($urandom_range(2047));
      end else if (pick >= 80) begin
         id = id + ID_W'($urandom_range(6)) - ID_W'(3);
      end
      pick = $urandom_range(99);
      if (pick < 55)
         delta = int'($urandom_range(2000)) - 1000;
      else if (pick < 75)
         delta = int'($urandom_range(12)) + 4090;
      else if (pick < 90)
         delta = int'($urandom_range(16383)) - 8192;
      else
         delta = int'($urandom_range(65535));
      if ($urandom_range(1))
         delta = -delta;
      enc = enc_trail[slot] + ENC_W'(delta);
      enc_trail[slot] = enc;
      send_frame(bus, id, enc, RAW_W'($urandom), RAW_W'($urandom));
   endtask

   task automatic program_ids(input logic [ID_W-1:0] ids[CSR_COUNT]);
      logic [CSR_IDX_W-1:0] order [CSR_COUNT];
      order = '{CSR_CHASSIS_BASE_ID, CSR_YAW_ID, CSR_FRICTION_BASE_ID,
                CSR_TRIGGER_ID, CSR_PITCH_ID};
      for (int k = 0; k < CSR_COUNT; k++) begin
         csr_valid <= 1'b1;
         csr_index <= order[k];
         csr_data <= ids[k];
         do @(posedge clock); while (!csr_ready);
         active_ids[order[k]] = ids[k];
      end
      csr_valid <= 1'b0;
   endtask

   // Wait out every outstanding result, then let the pipeline settle
   task automatic drain();
      do @(posedge clock); while (pending_results != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      active_ids = '{RST_CHASSIS_BASE_ID, RST_YAW_ID, RST_FRICTION_BASE_ID,
                     RST_TRIGGER_ID, RST_PITCH_ID};
      id_sets[0] = active_ids;
      // overlaps: chassis hides yaw, trigger hides pitch
      id_sets[1] = '{11'd0, 11'd2, 11'd0, 11'd3, 11'd3};
      id_sets[2] = '{11'd2047, 11'd2047, 11'd2047, 11'd0, 11'd2047};
      id_sets[3] = '{11'd2044, 11'd0, 11'd2046, 11'd2047, 11'd0};
      for (int k = 0; k < CSR_COUNT; k++)
         id_sets[4][k] = ID_W'($urandom_range(2047));
      id_sets[5] = active_ids;
      for (int k = 0; k < NUM_SLOTS; k++)
         enc_trail[k] = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // unmatched: extremes, wrong bus, just below the chassis range
      send_frame(1'b1, 11'd2047, 16'hFFFF, 16'h7FFF, 16'h8000);
      send_frame(1'b0, 11'd0, 16'h0000, 16'h8000, 16'h7FFF);
      send_frame(1'b0, RST_PITCH_ID, 16'h1234, 16'h0001, 16'h0001);
      send_frame(1'b1, RST_YAW_ID, 16'h1234, 16'h0001, 16'h0001);
      send_frame(1'b0, RST_CHASSIS_BASE_ID - 11'd1, 16'h0042, 16'h0010, 16'h0020);
      // calibration frames on every calibrating slot
      send_frame(1'b0, RST_CHASSIS_BASE_ID, 16'hFFFF, 16'h0100, 16'hFF00);
      send_frame(1'b0, RST_CHASSIS_BASE_ID + 11'd1, 16'd100, 16'h7FFF, 16'h7FFF);
      send_frame(1'b0, RST_CHASSIS_BASE_ID + 11'd2, 16'd8191, 16'h8000, 16'h8000);
      send_frame(1'b0, RST_CHASSIS_BASE_ID + 11'd3, 16'd8192, 16'h0000, 16'h0000);
      send_frame(1'b1, RST_FRICTION_BASE_ID, 16'd4000, 16'h0ABC, 16'hF123);
      send_frame(1'b1, RST_FRICTION_BASE_ID + 11'd1, 16'd60000, 16'hFFFF, 16'h0001);
      send_frame(1'b1, RST_TRIGGER_ID, 16'd30000, 16'h1111, 16'h2222);
      // yaw: exact half turn does not wrap, one past it does, both ways
      send_frame(1'b0, RST_YAW_ID, 16'd4096, 16'h7FFF, 16'h8000);
      send_frame(1'b0, RST_YAW_ID, 16'd0, 16'h8000, 16'h7FFF);
      send_frame(1'b0, RST_YAW_ID, 16'd4097, 16'h0005, 16'h0006);
      send_frame(1'b0, RST_YAW_ID, 16'd0, 16'h0007, 16'h0008);
      send_frame(1'b0, RST_YAW_ID, 16'hFFFF, 16'h0009, 16'h000A);
      send_frame(1'b0, RST_YAW_ID, 16'd0, 16'h000B, 16'h000C);
      // pitch: largest jumps in both directions
      send_frame(1'b1, RST_PITCH_ID, 16'hFFFF, 16'h8000, 16'h7FFF);
      send_frame(1'b1, RST_PITCH_ID, 16'd0, 16'h7FFF, 16'h8000);
      send_frame(1'b1, RST_PITCH_ID, 16'd12288, 16'hFFFF, 16'hFFFF);
      send_frame(1'b0, RST_CHASSIS_BASE_ID, 16'd1234, 16'h0001, 16'h0002);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase > 0) begin
            req_tvalid <= 1'b0;
            drain();
            program_ids(id_sets[phase]);
         end
         for (int chunk = 0; chunk < 4; chunk++) begin
            case ((chunk + phase) % 4)
               0: begin idle_pct = 0;  stall_pct = 0;  end
               1: begin idle_pct = 62; stall_pct = 0;  end
               2: begin idle_pct = 0;  stall_pct = 62; end
               default: begin idle_pct = 9; stall_pct = 9; end
            endcase
            repeat (RANDOM_FRAMES / 4) random_frame();
         end
      end
      req_tvalid <= 1'b0;
      drain();

      if (mismatch_total == 0 && pending_results == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
